@@ rtl/irme_pkg.sv @@
`default_nettype none

package irme_pkg;

  localparam int unsigned QUEUE_DEPTH = 4;

  localparam logic [7:0] HEADER_0 = 8'h55;
  localparam logic [7:0] HEADER_1 = 8'hFF;
  localparam logic [7:0] HEADER_2 = 8'h00;

  localparam int unsigned TOGGLE_BIT = 3;

  // One classified payload byte, as the back end needs it.
  typedef struct packed {
    logic [7:0] data;
    logic       first;
    logic       last;
    logic [7:0] sum;
  } irme_cmd_t;

  // Queue status seen by both ends.
  typedef struct packed {
    logic empty;
    logic full;
  } irme_qstat_t;

  // Start slot high, inverted data LSB first, even parity, stop slot low.
  function automatic logic [10:0] make_char(input logic [7:0] b);
    make_char = {1'b0, ^b, ~b, 1'b1};
  endfunction

endpackage

`default_nettype wire

@@ rtl/irme_if.sv @@
`default_nettype none

interface irme_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] payload_byte;
  logic       last_byte;

  modport source (output valid, output payload_byte, output last_byte, input ready);
  modport sink (input valid, input payload_byte, input last_byte, output ready);
endinterface

interface irme_out_if;
  logic        valid;
  logic        ready;
  logic [10:0] line_slots;
  logic        end_of_run;
  logic        end_of_message;

  modport source (output valid, output line_slots, output end_of_run,
                  output end_of_message, input ready);
  modport sink (input valid, input line_slots, input end_of_run,
                input end_of_message, output ready);
endinterface

`default_nettype wire

@@ rtl/irme_front.sv @@
`default_nettype none

module irme_front (
  input  wire logic               clk,
  input  wire logic               rst_n,
  irme_in_if.sink                 in_ch,
  input  wire irme_pkg::irme_qstat_t qstat,
  output logic                    push,
  output irme_pkg::irme_cmd_t     push_cmd
);

  logic       toggle_r, toggle_nxt;
  logic [7:0] sum_r, sum_nxt;
  logic       inside_r, inside_nxt;
  logic [7:0] byte_mod;
  logic [7:0] sum_base;

  assign in_ch.ready = !qstat.full;
  assign push        = in_ch.valid && !qstat.full;

  always_comb begin
    byte_mod = in_ch.payload_byte;
    if (!inside_r) begin
      byte_mod[irme_pkg::TOGGLE_BIT] = toggle_r;
    end
    sum_base = inside_r ? sum_r : 8'h00;
    sum_nxt  = sum_base + byte_mod;

    push_cmd.data  = byte_mod;
    push_cmd.first = !inside_r;
    push_cmd.last  = in_ch.last_byte;
    push_cmd.sum   = sum_nxt;

    toggle_nxt = inside_r ? toggle_r : !toggle_r;
    inside_nxt = !in_ch.last_byte;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      toggle_r <= 1'b0;
      sum_r    <= 8'h00;
      inside_r <= 1'b0;
    end else if (push) begin
      toggle_r <= toggle_nxt;
      sum_r    <= sum_nxt;
      inside_r <= inside_nxt;
    end
  end

endmodule

`default_nettype wire

@@ rtl/irme_queue.sv @@
`default_nettype none

module irme_queue #(
  parameter int unsigned DEPTH = irme_pkg::QUEUE_DEPTH
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  push,
  input  wire irme_pkg::irme_cmd_t   push_cmd,
  input  wire logic                  pop,
  output irme_pkg::irme_cmd_t        head,
  output irme_pkg::irme_qstat_t      qstat
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

  irme_pkg::irme_cmd_t mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0] count_r;

  assign qstat.empty = (count_r == '0);
  assign qstat.full  = (count_r == FULL_CNT);
  assign head        = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == LAST_PTR) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == LAST_PTR) ? '0 : rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        count_r <= count_r + 1'b1;
      end else if (pop && !push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

@@ rtl/irme_back.sv @@
`default_nettype none

module irme_back (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire irme_pkg::irme_cmd_t   head,
  input  wire irme_pkg::irme_qstat_t qstat,
  output logic                       pop,
  irme_out_if.source                 out_ch
);

  typedef enum logic [2:0] {
    S_START,
    S_HDR0,
    S_HDR1,
    S_HDR2,
    S_DATA,
    S_COMP,
    S_SUM,
    S_SCOMP
  } step_t;

  step_t       step_r, cur, nxt;
  logic        out_valid_r;
  logic [10:0] slots_r;
  logic        eor_r, eom_r;
  logic        load;
  logic [7:0]  chr;
  logic        eor, eom, done;

  assign out_ch.valid          = out_valid_r;
  assign out_ch.line_slots     = slots_r;
  assign out_ch.end_of_run     = eor_r;
  assign out_ch.end_of_message = eom_r;

  // A new character enters the output register when it is empty or being drained and the queue holds a command.
  assign load = (!out_valid_r || out_ch.ready) && !qstat.empty;
  assign pop  = load && done;

  always_comb begin
    cur = step_r;
    if (step_r == S_START && !qstat.empty) begin
      cur = head.first ? S_HDR0 : S_DATA;
    end
    chr  = irme_pkg::HEADER_0;
    eor  = 1'b0;
    eom  = 1'b0;
    done = 1'b0;
    nxt  = S_START;
    unique case (cur)
      S_START, S_HDR0: begin
        chr = irme_pkg::HEADER_0;
        nxt = S_HDR1;
      end
      S_HDR1: begin
        chr = irme_pkg::HEADER_1;
        nxt = S_HDR2;
      end
      S_HDR2: begin
        chr = irme_pkg::HEADER_2;
        nxt = S_DATA;
      end
      S_DATA: begin
        chr = head.data;
        nxt = S_COMP;
      end
      S_COMP: begin
        chr = ~head.data;
        if (head.last) begin
          nxt = S_SUM;
        end else begin
          eor  = 1'b1;
          done = 1'b1;
        end
      end
      S_SUM: begin
        chr = head.sum;
        nxt = S_SCOMP;
      end
      S_SCOMP: begin
        chr  = ~head.sum;
        eor  = 1'b1;
        eom  = 1'b1;
        done = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r      <= S_START;
      out_valid_r <= 1'b0;
    end else begin
      if (load) begin
        step_r      <= nxt;
        out_valid_r <= 1'b1;
        slots_r     <= irme_pkg::make_char(chr);
        eor_r       <= eor;
        eom_r       <= eom;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

@@ rtl/ir_message_frame_encoder_core.sv @@
// The first character of a byte is offered from the output register once the byte has
// passed through the command queue, when the back end is idle.
// Throughput: one character per cycle from the output register when out_ch is ready and the
// queue is not empty; two characters per byte, five more per message for header and checksum.
// Input bytes are taken each cycle while the command queue between front and back has room.
// Reset clears the toggle bit, checksum, message state, queue and output register.
`default_nettype none

module ir_message_frame_encoder_core #(
  parameter int unsigned QUEUE_DEPTH = irme_pkg::QUEUE_DEPTH
) (
  input  wire logic  clk,
  input  wire logic  rst_n,
  irme_in_if.sink    in_ch,
  irme_out_if.source out_ch
);

  irme_pkg::irme_cmd_t   push_cmd, head;
  irme_pkg::irme_qstat_t qstat;
  logic                  push, pop;

  irme_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .qstat    (qstat),
    .push     (push),
    .push_cmd (push_cmd)
  );

  irme_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_cmd (push_cmd),
    .pop      (pop),
    .head     (head),
    .qstat    (qstat)
  );

  irme_back u_back (
    .clk    (clk),
    .rst_n  (rst_n),
    .head   (head),
    .qstat  (qstat),
    .pop    (pop),
    .out_ch (out_ch)
  );

endmodule

`default_nettype wire
